// ===== rtl/core/heightmap_bilinear_mirror_sampler_assert.svh =====
// Assertion macros for the heightmap sampler.
`ifndef HEIGHTMAP_BILINEAR_MIRROR_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_BILINEAR_MIRROR_SAMPLER_ASSERT_SVH

`ifndef SYNTH
// Check while out of reset.
`define HBMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hbms assertion failed");
// Check at every edge, reset included.
`define HBMS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hbms assertion failed");
`else
`define HBMS_ASSERT(lbl, prop)
`define HBMS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/core/hbms_pkg.sv =====
`timescale 1ns / 1ps
package hbms_pkg;

  localparam int MAX_SIDE   = 257;
  localparam int MAX_STEP   = 64;
  localparam int FRAC_BITS  = 8;
  localparam int STRIDE     = (MAX_SIDE + 1) & ~1;
  localparam int GRID_DEPTH = STRIDE * MAX_SIDE;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int HEIGHT_W   = 24;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 24'd16776960;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_GRID_COLUMNS  = 2'd0,
    REG_GRID_ROWS     = 2'd1,
    REG_COLUMN_OFFSET = 2'd2,
    REG_ROW_OFFSET    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [12:0] rem;
    logic [7:0]  quo;
  } div_step_t;

  // Six restoring steps of a remainder; rem must start below div.
  function automatic logic [9:0] mod_bits6(input logic [9:0] rem, input logic [5:0] bits,
                                           input logic [9:0] div);
    logic [10:0] t;
    logic [9:0]  r;
    r = rem;
    for (int i = 5; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, div}) t = t - {1'b0, div};
      r = t[9:0];
    end
    return r;
  endfunction

  // Eight restoring division steps, one quotient bit each.
  function automatic div_step_t div_bits8(input logic [12:0] rem, input logic [7:0] bits,
                                          input logic [12:0] div);
    logic [13:0] t;
    div_step_t   res;
    res.rem = rem;
    res.quo = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {res.rem, bits[i]};
      res.quo[i] = (t >= {1'b0, div});
      if (res.quo[i]) t = t - {1'b0, div};
      res.rem = t[12:0];
    end
    return res;
  endfunction

  // Mirror period: zero acts as one, saturate at the grid side.
  function automatic logic [8:0] period_of(input logic [8:0] p);
    logic [8:0] r;
    r = p;
    if (p == 9'd0) r = 9'd1;
    else if (p > 9'(MAX_SIDE)) r = 9'(MAX_SIDE);
    return r;
  endfunction

  // Linear grid address: column + row * STRIDE.
  function automatic logic [ADDR_W-1:0] grid_addr(input logic [8:0] col, input logic [8:0] row);
    return ADDR_W'(col) + ADDR_W'(row) * ADDR_W'(STRIDE);
  endfunction

endpackage

// ===== rtl/core/hbms_ram.sv =====
`timescale 1ns / 1ps
module hbms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/heightmap_bilinear_mirror_sampler.sv =====
`timescale 1ns / 1ps
// Channel | Bus                         | Content
// in      | in_tvalid/tready/tdata/tuser | tuser: cmd; tdata: query_col, query_row,
//         |                             |   grid_step, load_col, load_row, load_value
// out     | out_tvalid/tready/tdata      | tdata: height
// cfg     | cfg_we/addr/wdata            | grid_columns, grid_rows, column_offset,
//         |                             |   row_offset
//
// One word per cycle while the output is not stalled.
// The path holds 13 stage registers and the output register: two remainder
// stages for the step snap, two for mirroring, the grid read, two multiply levels
// and three quotient stages for the final divide by step squared.
// Reset clears valid bits and registers only; grid contents stay undefined
// until loaded, so there is no clearing pass.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
module heightmap_bilinear_mirror_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [18:0] query_col, [37:19] query_row, [44:38] grid_step, [53:45] load_col,
  // [62:54] load_row, [78:63] load_value, [79] zero
  input  logic [79:0] in_tdata,
  // [0] cmd
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [23:0] height
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);

`include "heightmap_bilinear_mirror_sampler_assert.svh"

  localparam int AW = hbms_pkg::ADDR_W;

  // ---------------- configuration ----------------
  logic [8:0]         cols_r, rows_r;
  logic signed [11:0] col_off_r, row_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= 9'(hbms_pkg::MAX_SIDE);
      rows_r    <= 9'(hbms_pkg::MAX_SIDE);
      col_off_r <= '0;
      row_off_r <= '0;
    end else if (cfg_we) begin
      case (hbms_pkg::cfg_reg_t'(cfg_addr))
        hbms_pkg::REG_GRID_COLUMNS:  cols_r    <= cfg_wdata[8:0];
        hbms_pkg::REG_GRID_ROWS:     rows_r    <= cfg_wdata[8:0];
        hbms_pkg::REG_COLUMN_OFFSET: col_off_r <= cfg_wdata;
        hbms_pkg::REG_ROW_OFFSET:    row_off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [8:0] per_c, per_r;
  logic [9:0] per2_c, per2_r;
  assign per_c  = hbms_pkg::period_of(cols_r);
  assign per_r  = hbms_pkg::period_of(rows_r);
  assign per2_c = {per_c, 1'b0};
  assign per2_r = {per_r, 1'b0};

  // ---------------- pipeline control ----------------
  // Advance every stage together whenever the output register can move.
  logic        adv;
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic [13:1] vld_r, vld_nxt;
  logic [6:1]  qry_r, qry_nxt;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    vld_nxt    = '0;
    qry_nxt    = '0;
    vld_nxt[1] = in_tvalid;
    qry_nxt[1] = in_tuser;
    for (int k = 2; k <= 6; k++) begin
      vld_nxt[k] = vld_r[k-1];
      qry_nxt[k] = qry_r[k-1];
    end
    // Loads retire at the grid write; only queries go further.
    vld_nxt[7] = vld_r[6] && (qry_r[6] == hbms_pkg::CMD_QUERY);
    for (int k = 8; k <= 13; k++) vld_nxt[k] = vld_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      qry_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      qry_r       <= qry_nxt;
      out_valid_r <= vld_r[13];
    end
  end

  // ---------------- stage 1: unpack, clamp step, floor coordinates ----------------
  logic signed [18:0] in_qc, in_qr;
  logic [6:0]         in_step_raw, st1_nxt;
  logic signed [10:0] fc, fr;
  logic [10:0]        fc_abs, fr_abs;

  assign in_qc       = in_tdata[18:0];
  assign in_qr       = in_tdata[37:19];
  assign in_step_raw = in_tdata[44:38];
  assign fc          = in_qc[18:8];
  assign fr          = in_qr[18:8];
  assign fc_abs      = fc[10] ? 11'(-fc) : 11'(fc);
  assign fr_abs      = fr[10] ? 11'(-fr) : 11'(fr);

  always_comb begin
    st1_nxt = in_step_raw;
    if (in_step_raw == 7'd0) st1_nxt = 7'd1;
    else if (in_step_raw > 7'(hbms_pkg::MAX_STEP)) st1_nxt = 7'(hbms_pkg::MAX_STEP);
  end

  logic [6:0]  s1_step_r;
  logic        s1_cneg_r, s1_rneg_r;
  logic [10:0] s1_cabs_r, s1_rabs_r;
  logic [7:0]  s1_cfrac_r, s1_rfrac_r;
  logic [8:0]  s1_lcol_r, s1_lrow_r;
  logic [15:0] s1_lval_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_step_r  <= st1_nxt;
      s1_cneg_r  <= fc[10];
      s1_rneg_r  <= fr[10];
      s1_cabs_r  <= fc_abs;
      s1_rabs_r  <= fr_abs;
      s1_cfrac_r <= in_qc[7:0];
      s1_rfrac_r <= in_qr[7:0];
      s1_lcol_r  <= in_tdata[53:45];
      s1_lrow_r  <= in_tdata[62:54];
      s1_lval_r  <= in_tdata[78:63];
    end
  end

  // ---------------- stage 2: upper half of |floor| mod step ----------------
  logic [9:0] c2_nxt, r2_nxt;
  assign c2_nxt = hbms_pkg::mod_bits6('0, {1'b0, s1_cabs_r[10:6]}, {3'b0, s1_step_r});
  assign r2_nxt = hbms_pkg::mod_bits6('0, {1'b0, s1_rabs_r[10:6]}, {3'b0, s1_step_r});

  logic [6:0]  s2_step_r;
  logic        s2_cneg_r, s2_rneg_r;
  logic [10:0] s2_cabs_r, s2_rabs_r;
  logic [5:0]  s2_crem_r, s2_rrem_r;
  logic [7:0]  s2_cfrac_r, s2_rfrac_r;
  logic [8:0]  s2_lcol_r, s2_lrow_r;
  logic [15:0] s2_lval_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_step_r  <= s1_step_r;
      s2_cneg_r  <= s1_cneg_r;
      s2_rneg_r  <= s1_rneg_r;
      s2_cabs_r  <= s1_cabs_r;
      s2_rabs_r  <= s1_rabs_r;
      s2_crem_r  <= c2_nxt[5:0];
      s2_rrem_r  <= r2_nxt[5:0];
      s2_cfrac_r <= s1_cfrac_r;
      s2_rfrac_r <= s1_rfrac_r;
      s2_lcol_r  <= s1_lcol_r;
      s2_lrow_r  <= s1_lrow_r;
      s2_lval_r  <= s1_lval_r;
    end
  end

  // ---------------- stage 3: finish remainder, snap, fractional offset ----------------
  logic [9:0]         c3_rem, r3_rem;
  logic [10:0]        cmag, rmag;
  logic signed [11:0] cs_nxt, rs_nxt;
  logic signed [7:0]  cd, rd;

  assign c3_rem = hbms_pkg::mod_bits6({4'b0, s2_crem_r}, s2_cabs_r[5:0], {3'b0, s2_step_r});
  assign r3_rem = hbms_pkg::mod_bits6({4'b0, s2_rrem_r}, s2_rabs_r[5:0], {3'b0, s2_step_r});
  // Truncating snap: keep the sign, drop the remainder from the magnitude.
  assign cmag   = s2_cabs_r - {5'b0, c3_rem[5:0]};
  assign rmag   = s2_rabs_r - {5'b0, r3_rem[5:0]};
  assign cs_nxt = s2_cneg_r ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
  assign rs_nxt = s2_rneg_r ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  assign cd     = s2_cneg_r ? -$signed({2'b0, c3_rem[5:0]}) : $signed({2'b0, c3_rem[5:0]});
  assign rd     = s2_rneg_r ? -$signed({2'b0, r3_rem[5:0]}) : $signed({2'b0, r3_rem[5:0]});

  logic [6:0]         s3_step_r;
  logic signed [11:0] s3_cs_r, s3_rs_r;
  logic signed [15:0] s3_dh_r, s3_dv_r;
  logic [8:0]         s3_lcol_r, s3_lrow_r;
  logic [15:0]        s3_lval_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_step_r <= s2_step_r;
      s3_cs_r   <= cs_nxt;
      s3_rs_r   <= rs_nxt;
      s3_dh_r   <= $signed({cd, s2_cfrac_r});
      s3_dv_r   <= $signed({rd, s2_rfrac_r});
      s3_lcol_r <= s2_lcol_r;
      s3_lrow_r <= s2_lrow_r;
      s3_lval_r <= s2_lval_r;
    end
  end

  // ---------------- stage 4: offsets, corners, weights ----------------
  logic signed [12:0] c0, c1, r0, r1, step_s;
  logic signed [16:0] dd_s, dh_s, dv_s;

  assign step_s = $signed({6'b0, s3_step_r});
  assign c0     = $signed({s3_cs_r[11], s3_cs_r}) + $signed({col_off_r[11], col_off_r});
  assign r0     = $signed({s3_rs_r[11], s3_rs_r}) + $signed({row_off_r[11], row_off_r});
  assign c1     = c0 + step_s;
  assign r1     = r0 + step_s;
  assign dd_s   = $signed({2'b0, s3_step_r, 8'b0});
  assign dh_s   = $signed({s3_dh_r[15], s3_dh_r});
  assign dv_s   = $signed({s3_dv_r[15], s3_dv_r});

  logic [11:0]        s4_ac0_r, s4_ac1_r, s4_ar0_r, s4_ar1_r;
  logic signed [16:0] s4_wh_r, s4_dh_r, s4_wv_r, s4_dv_r;
  logic [12:0]        s4_sq_r;
  logic [8:0]         s4_lcol_r, s4_lrow_r;
  logic [15:0]        s4_lval_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ac0_r  <= c0[12] ? 12'(-c0) : 12'(c0);
      s4_ac1_r  <= c1[12] ? 12'(-c1) : 12'(c1);
      s4_ar0_r  <= r0[12] ? 12'(-r0) : 12'(r0);
      s4_ar1_r  <= r1[12] ? 12'(-r1) : 12'(r1);
      s4_wh_r   <= dd_s - dh_s;
      s4_wv_r   <= dd_s - dv_s;
      s4_dh_r   <= dh_s;
      s4_dv_r   <= dv_s;
      s4_sq_r   <= 13'({6'b0, s3_step_r} * {6'b0, s3_step_r});
      s4_lcol_r <= s3_lcol_r;
      s4_lrow_r <= s3_lrow_r;
      s4_lval_r <= s3_lval_r;
    end
  end

  // ---------------- stage 5: upper half of |corner| mod 2*period ----------------
  logic [11:0]        s5_ac0_r, s5_ac1_r, s5_ar0_r, s5_ar1_r;
  logic [9:0]         s5_mc0_r, s5_mc1_r, s5_mr0_r, s5_mr1_r;
  logic signed [16:0] s5_wh_r, s5_dh_r, s5_wv_r, s5_dv_r;
  logic [12:0]        s5_sq_r;
  logic [8:0]         s5_lcol_r, s5_lrow_r;
  logic [15:0]        s5_lval_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ac0_r  <= s4_ac0_r;
      s5_ac1_r  <= s4_ac1_r;
      s5_ar0_r  <= s4_ar0_r;
      s5_ar1_r  <= s4_ar1_r;
      s5_mc0_r  <= hbms_pkg::mod_bits6('0, s4_ac0_r[11:6], per2_c);
      s5_mc1_r  <= hbms_pkg::mod_bits6('0, s4_ac1_r[11:6], per2_c);
      s5_mr0_r  <= hbms_pkg::mod_bits6('0, s4_ar0_r[11:6], per2_r);
      s5_mr1_r  <= hbms_pkg::mod_bits6('0, s4_ar1_r[11:6], per2_r);
      s5_wh_r   <= s4_wh_r;
      s5_dh_r   <= s4_dh_r;
      s5_wv_r   <= s4_wv_r;
      s5_dv_r   <= s4_dv_r;
      s5_sq_r   <= s4_sq_r;
      s5_lcol_r <= s4_lcol_r;
      s5_lrow_r <= s4_lrow_r;
      s5_lval_r <= s4_lval_r;
    end
  end

  // ---------------- stage 6: finish mod 2*period ----------------
  logic [9:0]         s6_mc0_r, s6_mc1_r, s6_mr0_r, s6_mr1_r;
  logic signed [16:0] s6_wh_r, s6_dh_r, s6_wv_r, s6_dv_r;
  logic [12:0]        s6_sq_r;
  logic [8:0]         s6_lcol_r, s6_lrow_r;
  logic [15:0]        s6_lval_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_mc0_r  <= hbms_pkg::mod_bits6(s5_mc0_r, s5_ac0_r[5:0], per2_c);
      s6_mc1_r  <= hbms_pkg::mod_bits6(s5_mc1_r, s5_ac1_r[5:0], per2_c);
      s6_mr0_r  <= hbms_pkg::mod_bits6(s5_mr0_r, s5_ar0_r[5:0], per2_r);
      s6_mr1_r  <= hbms_pkg::mod_bits6(s5_mr1_r, s5_ar1_r[5:0], per2_r);
      s6_wh_r   <= s5_wh_r;
      s6_dh_r   <= s5_dh_r;
      s6_wv_r   <= s5_wv_r;
      s6_dv_r   <= s5_dv_r;
      s6_sq_r   <= s5_sq_r;
      s6_lcol_r <= s5_lcol_r;
      s6_lrow_r <= s5_lrow_r;
      s6_lval_r <= s5_lval_r;
    end
  end

  // ---------------- reflect, address, grid access ----------------
  // Upper half of the doubled period runs backward.
  logic [8:0] mc0, mc1, mr0, mr1;
  logic [9:0] t_c0, t_c1, t_r0, t_r1;

  assign t_c0 = (s6_mc0_r >= {1'b0, per_c}) ? (per2_c - 10'd1 - s6_mc0_r) : s6_mc0_r;
  assign t_c1 = (s6_mc1_r >= {1'b0, per_c}) ? (per2_c - 10'd1 - s6_mc1_r) : s6_mc1_r;
  assign t_r0 = (s6_mr0_r >= {1'b0, per_r}) ? (per2_r - 10'd1 - s6_mr0_r) : s6_mr0_r;
  assign t_r1 = (s6_mr1_r >= {1'b0, per_r}) ? (per2_r - 10'd1 - s6_mr1_r) : s6_mr1_r;
  assign mc0  = t_c0[8:0];
  assign mc1  = t_c1[8:0];
  assign mr0  = t_r0[8:0];
  assign mr1  = t_r1[8:0];

  // Loads write here, in order with the reads of the queries around them.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ra00, ra10, ra01, ra11;
  logic [15:0]   h00, h10, h01, h11;

  assign ram_we    = adv && vld_r[6] && (qry_r[6] == hbms_pkg::CMD_LOAD) &&
                     (s6_lcol_r < 9'(hbms_pkg::MAX_SIDE)) &&
                     (s6_lrow_r < 9'(hbms_pkg::MAX_SIDE));
  assign ram_waddr = hbms_pkg::grid_addr(s6_lcol_r, s6_lrow_r);
  assign ra00      = hbms_pkg::grid_addr(mc0, mr0);
  assign ra10      = hbms_pkg::grid_addr(mc1, mr0);
  assign ra01      = hbms_pkg::grid_addr(mc0, mr1);
  assign ra11      = hbms_pkg::grid_addr(mc1, mr1);

  // Four copies, each written by every in-range load, give four reads per cycle while the pipe advances.
  hbms_ram #(.WIDTH(hbms_pkg::SAMPLE_W), .DEPTH(hbms_pkg::GRID_DEPTH)) u_ram00 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(s6_lval_r),
    .re(adv), .raddr(ra00), .rdata(h00));
  hbms_ram #(.WIDTH(hbms_pkg::SAMPLE_W), .DEPTH(hbms_pkg::GRID_DEPTH)) u_ram10 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(s6_lval_r),
    .re(adv), .raddr(ra10), .rdata(h10));
  hbms_ram #(.WIDTH(hbms_pkg::SAMPLE_W), .DEPTH(hbms_pkg::GRID_DEPTH)) u_ram01 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(s6_lval_r),
    .re(adv), .raddr(ra01), .rdata(h01));
  hbms_ram #(.WIDTH(hbms_pkg::SAMPLE_W), .DEPTH(hbms_pkg::GRID_DEPTH)) u_ram11 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(s6_lval_r),
    .re(adv), .raddr(ra11), .rdata(h11));

  // ---------------- stage 7: samples arrive ----------------
  logic signed [16:0] s7_wh_r, s7_dh_r, s7_wv_r, s7_dv_r;
  logic [12:0]        s7_sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_wh_r <= s6_wh_r;
      s7_dh_r <= s6_dh_r;
      s7_wv_r <= s6_wv_r;
      s7_dv_r <= s6_dv_r;
      s7_sq_r <= s6_sq_r;
    end
  end

  // ---------------- stage 8: horizontal products ----------------
  logic signed [33:0] p00, p10, p01, p11;
  assign p00 = 34'($signed({1'b0, h00}) * s7_wh_r);
  assign p10 = 34'($signed({1'b0, h10}) * s7_dh_r);
  assign p01 = 34'($signed({1'b0, h01}) * s7_wh_r);
  assign p11 = 34'($signed({1'b0, h11}) * s7_dh_r);

  logic signed [33:0] s8_p00_r, s8_p10_r, s8_p01_r, s8_p11_r;
  logic signed [16:0] s8_wv_r, s8_dv_r;
  logic [36:0]        s8_thr_r;
  logic [12:0]        s8_sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_p00_r <= p00;
      s8_p10_r <= p10;
      s8_p01_r <= p01;
      s8_p11_r <= p11;
      s8_wv_r  <= s7_wv_r;
      s8_dv_r  <= s7_dv_r;
      // Quotient saturates once the scaled sum reaches this bound.
      s8_thr_r <= {24'b0, s7_sq_r} * {13'b0, hbms_pkg::HEIGHT_MAX};
      s8_sq_r  <= s7_sq_r;
    end
  end

  // ---------------- stage 9: row sums ----------------
  logic signed [34:0] s9_a_r, s9_b_r;
  logic signed [16:0] s9_wv_r, s9_dv_r;
  logic [36:0]        s9_thr_r;
  logic [12:0]        s9_sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_a_r   <= $signed({s8_p00_r[33], s8_p00_r}) + $signed({s8_p10_r[33], s8_p10_r});
      s9_b_r   <= $signed({s8_p01_r[33], s8_p01_r}) + $signed({s8_p11_r[33], s8_p11_r});
      s9_wv_r  <= s8_wv_r;
      s9_dv_r  <= s8_dv_r;
      s9_thr_r <= s8_thr_r;
      s9_sq_r  <= s8_sq_r;
    end
  end

  // ---------------- stage 10: vertical products ----------------
  logic signed [51:0] s10_ma_r, s10_mb_r;
  logic [36:0]        s10_thr_r;
  logic [12:0]        s10_sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_ma_r  <= $signed({{17{s9_a_r[34]}}, s9_a_r}) * $signed({{35{s9_wv_r[16]}}, s9_wv_r});
      s10_mb_r  <= $signed({{17{s9_b_r[34]}}, s9_b_r}) * $signed({{35{s9_dv_r[16]}}, s9_dv_r});
      s10_thr_r <= s9_thr_r;
      s10_sq_r  <= s9_sq_r;
    end
  end

  // ---------------- stage 11: total, scale, range check ----------------
  logic signed [52:0] n_sum;
  logic signed [52:0] m_sum;
  logic               n_neg, n_sat;

  assign n_sum = $signed({s10_ma_r[51], s10_ma_r}) + $signed({s10_mb_r[51], s10_mb_r});
  assign m_sum = n_sum >>> hbms_pkg::FRAC_BITS;
  assign n_neg = n_sum[52];
  assign n_sat = !n_neg && (m_sum[44:0] >= {8'b0, s10_thr_r});

  logic        s11_neg_r, s11_sat_r;
  logic [23:0] s11_lo_r;
  logic [12:0] s11_rem_r, s11_sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_neg_r <= n_neg;
      s11_sat_r <= n_sat;
      s11_lo_r  <= m_sum[23:0];
      s11_rem_r <= {1'b0, m_sum[35:24]};
      s11_sq_r  <= s10_sq_r;
    end
  end

  // ---------------- stages 12, 13, out: divide by step squared ----------------
  hbms_pkg::div_step_t d12, d13, d14;
  assign d12 = hbms_pkg::div_bits8(s11_rem_r, s11_lo_r[23:16], s11_sq_r);

  logic        s12_neg_r, s12_sat_r;
  logic [15:0] s12_lo_r;
  logic [12:0] s12_rem_r, s12_sq_r;
  logic [7:0]  s12_q_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_neg_r <= s11_neg_r;
      s12_sat_r <= s11_sat_r;
      s12_lo_r  <= s11_lo_r[15:0];
      s12_rem_r <= d12.rem;
      s12_sq_r  <= s11_sq_r;
      s12_q_r   <= d12.quo;
    end
  end

  assign d13 = hbms_pkg::div_bits8(s12_rem_r, s12_lo_r[15:8], s12_sq_r);

  logic        s13_neg_r, s13_sat_r;
  logic [7:0]  s13_lo_r;
  logic [12:0] s13_rem_r, s13_sq_r;
  logic [15:0] s13_q_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s13_neg_r <= s12_neg_r;
      s13_sat_r <= s12_sat_r;
      s13_lo_r  <= s12_lo_r[7:0];
      s13_rem_r <= d13.rem;
      s13_sq_r  <= s12_sq_r;
      s13_q_r   <= {s12_q_r, d13.quo};
    end
  end

  assign d14 = hbms_pkg::div_bits8(s13_rem_r, s13_lo_r, s13_sq_r);

  logic [23:0] height_nxt;
  always_comb begin
    height_nxt = {s13_q_r, d14.quo};
    if (s13_neg_r) height_nxt = '0;
    else if (s13_sat_r) height_nxt = hbms_pkg::HEIGHT_MAX;
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= height_nxt;
  end

  // ---------------- checks ----------------
  `HBMS_ASSERT(a_stall_freezes_pipe, (out_valid_r && !out_tready) |=> $stable(vld_r))
  `HBMS_ASSERT(a_snap_rem_below_step, vld_r[2] |-> (s2_crem_r < s2_step_r))
  `HBMS_ASSERT(a_mirror_in_period, (vld_r[6] && qry_r[6]) |-> (mc0 < per_c && mr1 < per_r))
  `HBMS_ASSERT(a_height_in_range, out_valid_r |-> (out_data_r <= hbms_pkg::HEIGHT_MAX))
  `HBMS_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid_r && vld_r == '0))

endmodule
